### rtl/tmcm_pkg.sv
package tmcm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int MODE_W   = 2;
	localparam int MARGIN_W = 8;
	localparam int HIGH_W   = 13;
	localparam int SUM_W    = 16;
	localparam int INDEX_W  = 2;

	localparam logic [MODE_W-1:0] MODE_CLOSING  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LEARNING = 2'd2;

	localparam logic [INDEX_W-1:0] REG_LOW_LIMIT    = 2'd0;
	localparam logic [INDEX_W-1:0] REG_LEARN_MARGIN = 2'd1;
	localparam logic [INDEX_W-1:0] REG_LEARN_FLOOR  = 2'd2;

	localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST    = 12'd100;
	localparam logic [MARGIN_W-1:0] LEARN_MARGIN_RST = 8'd30;
	localparam logic [SAMPLE_W-1:0] LEARN_FLOOR_RST  = 12'd200;
	localparam logic [HIGH_W-1:0]   HIGH_LIMIT_RST   = 13'd1800;

	typedef struct packed {
		logic [SAMPLE_W-1:0] low_limit;
		logic [MARGIN_W-1:0] learn_margin;
		logic [SAMPLE_W-1:0] learn_floor;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [MODE_W-1:0]   motor_mode;
		logic                settled;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic                average_new;
		logic                trip;
		logic                fault;
		logic [HIGH_W-1:0]   high_limit;
	} result_t;

endpackage

### rtl/tmcm_ifs.sv
interface tmcm_meas_if;
	import tmcm_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic [MODE_W-1:0]   motor_mode;
	logic                settled;

	modport source (output valid, sample, motor_mode, settled, input ready);
	modport sink (input valid, sample, motor_mode, settled, output ready);
endinterface

interface tmcm_status_if;
	import tmcm_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] average;
	logic                average_new;
	logic                trip;
	logic                fault;
	logic [HIGH_W-1:0]   high_limit;

	modport source (output valid, average, average_new, trip, fault, high_limit, input ready);
	modport sink (input valid, average, average_new, trip, fault, high_limit, output ready);
endinterface

interface tmcm_cfg_if;
	import tmcm_pkg::*;

	logic                valid;
	logic                ready;
	logic [INDEX_W-1:0]  index;
	logic [SAMPLE_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/tmcm_cfg_regs.sv
module tmcm_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	tmcm_cfg_if.sink        wr,
	output tmcm_pkg::cfg_t  cfg
);
	import tmcm_pkg::*;

	cfg_t cfg_q;

	assign wr.ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_limit    <= LOW_LIMIT_RST;
			cfg_q.learn_margin <= LEARN_MARGIN_RST;
			cfg_q.learn_floor  <= LEARN_FLOOR_RST;
		end else if (wr.valid) begin
			unique case (wr.index)
				REG_LOW_LIMIT:    cfg_q.low_limit    <= wr.data;
				REG_LEARN_MARGIN: cfg_q.learn_margin <= wr.data[MARGIN_W-1:0];
				REG_LEARN_FLOOR:  cfg_q.learn_floor  <= wr.data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/tmcm_calc.sv
module tmcm_calc #(
	parameter int WINDOW      = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tmcm_pkg::item_t   item,
	input  tmcm_pkg::cfg_t    cfg,
	output tmcm_pkg::result_t res
);
	import tmcm_pkg::*;

	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int DIV    = WINDOW - 2;
	localparam int DIV_L  = $clog2(DIV);
	localparam int DIV_SH = SUM_W + DIV_L;
	localparam int PROD_W = 2 * SUM_W + 1;
	// Reciprocal exact for every SUM_W-bit dividend.
	localparam logic [63:0] DIV_M64 = ((64'd1 << DIV_SH) + 64'(DIV) - 64'd1) / 64'(DIV);
	localparam logic [SUM_W:0] DIV_M = DIV_M64[SUM_W:0];
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW);

	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [HIGH_W-1:0]   high_q;
	logic                fault_q;

	logic [SAMPLE_W-1:0] s;
	logic                take;
	logic                done;
	logic [CNT_W-1:0]    cnt_inc;
	logic [SUM_W-1:0]    sum_add;
	logic [SUM_W-1:0]    trimmed;
	logic [SAMPLE_W-1:0] max_n;
	logic [SAMPLE_W-1:0] min_n;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-1:0]   quot;
	logic [SAMPLE_W-1:0] avg_new;
	logic [SAMPLE_W-1:0] avg_next;
	logic [HIGH_W-1:0]   high_next;
	logic                trip;

	always_comb begin
		s       = item.sample & SAMPLE_MASK;
		take    = (((item.motor_mode == MODE_CLOSING) && item.settled)
		           || (item.motor_mode == MODE_LEARNING)) && (s != '0);
		sum_add = sum_q + SUM_W'(s);
		max_n   = (max_q < s) ? s : max_q;
		min_n   = (min_q > s) ? s : min_q;
		cnt_inc = cnt_q + CNT_W'(1);
		done    = take && (cnt_inc >= CNT_LAST);
		trimmed = sum_add - SUM_W'(min_n) - SUM_W'(max_n);
		prod    = PROD_W'(trimmed) * PROD_W'(DIV_M);
		quot    = prod >> DIV_SH;
		avg_new = quot[SAMPLE_W-1:0];
		// Range check uses the limit from before any learning update.
		trip    = done && ((HIGH_W'(avg_new) >= high_q) || (avg_new <= cfg.low_limit));
		avg_next = done ? avg_new : avg_q;
		if ((item.motor_mode == MODE_LEARNING) && (avg_next > cfg.learn_floor)) begin
			high_next = HIGH_W'(avg_next) + HIGH_W'(cfg.learn_margin);
		end else begin
			high_next = high_q;
		end
	end

	assign res.average     = avg_next;
	assign res.average_new = done;
	assign res.trip        = trip;
	assign res.fault       = fault_q | trip;
	assign res.high_limit  = high_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			max_q   <= '0;
			min_q   <= '1;
			avg_q   <= '0;
			high_q  <= HIGH_LIMIT_RST;
			fault_q <= 1'b0;
		end else if (step) begin
			if (take) begin
				if (done) begin
					cnt_q <= '0;
					sum_q <= '0;
					max_q <= '0;
					min_q <= '1;
				end else begin
					cnt_q <= cnt_inc;
					sum_q <= sum_add;
					max_q <= max_n;
					min_q <= min_n;
				end
			end
			avg_q   <= avg_next;
			high_q  <= high_next;
			fault_q <= fault_q | trip;
		end
	end

endmodule

### rtl/trimmed_mean_current_monitor_top.sv
// Channel | Role | Payload                                        | Request moves
// meas    | sink | sample[11:0] motor_mode[1:0] settled           | one current sample per tick
// status  | src  | average[11:0] average_new trip fault           | one status per sample
//         |      | high_limit[12:0]                               |
// cfg     | sink | index[1:0] data[11:0]                          | one register write
//
// Each sample request passes from meas to status through the input register and
// then the result register. One request enters every cycle unless both are full.
// Window state is updated as the request leaves the input register.
// Reset clears window state and loads default limits; no clearing pass.
// A stall on status holds both registers; meas.ready drops only when both are full.
module trimmed_mean_current_monitor_top #(
	parameter int WINDOW      = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	tmcm_meas_if.sink     meas,
	tmcm_status_if.source status,
	tmcm_cfg_if.sink      cfg
);
	import tmcm_pkg::*;

	cfg_t    cfg_val;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s1;
	logic    meas_acc;

	// Register file for limits and learning settings.
	tmcm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.cfg    (cfg_val)
	);

	// Advance stage 1 when the result register is empty or being drained.
	assign adv_s1     = valid_s1 && (!valid_s2 || status.ready);
	assign meas.ready = !valid_s1 || adv_s1;
	assign meas_acc   = meas.valid && meas.ready;

	// Input register: hold the request until it can move on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= meas_acc || (valid_s1 && !adv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (meas_acc) begin
			item_s1.sample     <= meas.sample;
			item_s1.motor_mode <= meas.motor_mode;
			item_s1.settled    <= meas.settled;
		end
	end

	// Window accumulate, trimmed mean, range check and learning.
	tmcm_calc #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_val),
		.res    (res_comb)
	);

	// Result register: hold the status until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= adv_s1 || (valid_s2 && !status.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign status.valid       = valid_s2;
	assign status.average     = res_s2.average;
	assign status.average_new = res_s2.average_new;
	assign status.trip        = res_s2.trip;
	assign status.fault       = res_s2.fault;
	assign status.high_limit  = res_s2.high_limit;

endmodule
